[sv/block_stream_deframer_top_defines.svh]
// Assertion macros shared by the deframer. Define NO_ASSERTIONS to compile them out.
`ifndef BLOCK_STREAM_DEFRAMER_TOP_DEFINES_SVH
`define BLOCK_STREAM_DEFRAMER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define BSD_ASSERT(lbl, clk_s, rst_n_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
    else $error("block_stream_deframer assertion failed");
// Checked on every clock edge, including during reset.
`define BSD_ASSERT_ALL(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("block_stream_deframer assertion failed");
`else
`define BSD_ASSERT(lbl, clk_s, rst_n_s, prop)
`define BSD_ASSERT_ALL(lbl, clk_s, prop)
`endif

`endif

[sv/bsd_pkg.sv]
`timescale 1ns / 1ps

package bsd_pkg;

  localparam int DATA_W      = 16;
  localparam int POS_OUT_W   = 32;
  localparam int PL_W        = 30;
  localparam int COUNT_WORD  = 6;
  localparam int SIZE_WORD   = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_TRUNC   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [POS_OUT_W-1:0]      position;
    logic signed [DATA_W-1:0]  payload_value;
    logic                      last_in_block;
  } result_t;

  // Up to two results produced by one stream word, packed from res0.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

[sv/bsd_core.sv]
`timescale 1ns / 1ps

module bsd_core #(
  parameter int HEADER_WORDS  = 8,
  parameter int POSITION_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [bsd_pkg::DATA_W-1:0] in_data_word,
  input  logic                          in_end_of_stream,
  input  logic                          room,
  output bsd_pkg::push_t                push
);
  import bsd_pkg::*;

  localparam int STEP_W = $clog2(HEADER_WORDS);

  // Input register.
  logic                     item_v_r;
  logic signed [DATA_W-1:0] word_r;
  logic                     eos_r;

  // Deframer state.
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [DATA_W-1:0]        wfc_r, wfc_nxt;
  logic [PL_W-1:0]          left_r, left_nxt;
  logic [POSITION_BITS-1:0] wpos_r, wpos_nxt;
  logic                     halted_r, halted_nxt;

  logic                     consume;
  logic [POSITION_BITS-1:0] pos;
  logic [POS_OUT_W-1:0]     pos_out;
  logic [PL_W-1:0]          prod;
  logic                     first_v, trunc_v;
  result_t                  first_res, trunc_res;

  assign consume  = item_v_r && room;
  assign in_ready = !item_v_r || consume;
  assign pos      = wpos_r + POSITION_BITS'(1);
  assign pos_out  = POS_OUT_W'(pos);
  // Both counts are known non-negative when the product is used.
  assign prod     = PL_W'(wfc_r[DATA_W-2:0]) * PL_W'(word_r[DATA_W-2:0]);

  always_comb begin
    step_nxt   = step_r;
    wfc_nxt    = wfc_r;
    left_nxt   = left_r;
    wpos_nxt   = wpos_r;
    halted_nxt = halted_r;
    first_v    = 1'b0;
    trunc_v    = 1'b0;
    first_res  = '{kind: KIND_START, position: pos_out, payload_value: '0,
                   last_in_block: 1'b0};
    trunc_res  = '{kind: KIND_TRUNC, position: pos_out, payload_value: '0,
                   last_in_block: 1'b0};
    if (!halted_r) begin
      wpos_nxt = pos;
      if (step_r == '0 && left_r != '0) begin
        first_v                 = 1'b1;
        first_res.kind          = KIND_PAYLOAD;
        first_res.payload_value = word_r;
        first_res.last_in_block = (left_r == PL_W'(1));
        left_nxt                = left_r - PL_W'(1);
      end else begin
        if (step_r == '0) begin
          first_v = 1'b1;
        end
        if (step_r == STEP_W'(COUNT_WORD)) begin
          wfc_nxt = word_r;
        end
        if (step_r == STEP_W'(SIZE_WORD)) begin
          if (wfc_r[DATA_W-1] || word_r[DATA_W-1]) begin
            first_v        = 1'b1;
            first_res.kind = KIND_ERROR;
            halted_nxt     = 1'b1;
          end else begin
            left_nxt = prod;
          end
        end
        if (step_r == STEP_W'(HEADER_WORDS - 1)) begin
          step_nxt = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      // The stream-end check is skipped when a count error halts the block.
      if (eos_r && !halted_nxt) begin
        trunc_v  = (step_nxt != '0) || (left_nxt != '0);
        step_nxt = '0;
        left_nxt = '0;
        wpos_nxt = '0;
      end
    end
  end

  always_comb begin
    push.count = consume ? ({1'b0, first_v} + {1'b0, trunc_v}) : 2'd0;
    push.res0  = first_v ? first_res : trunc_res;
    push.res1  = trunc_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      step_r   <= '0;
      wfc_r    <= '0;
      left_r   <= '0;
      wpos_r   <= '0;
      halted_r <= 1'b0;
    end else begin
      if (in_ready) begin
        item_v_r <= in_valid;
      end
      if (consume) begin
        step_r   <= step_nxt;
        wfc_r    <= wfc_nxt;
        left_r   <= left_nxt;
        wpos_r   <= wpos_nxt;
        halted_r <= halted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_data_word;
      eos_r  <= in_end_of_stream;
    end
  end

endmodule

[sv/bsd_rq.sv]
`timescale 1ns / 1ps

module bsd_rq (
  input  logic             clk,
  input  logic             rst_n,
  input  bsd_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output bsd_pkg::result_t head
);
  import bsd_pkg::*;

  result_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_r, rd_r;
  logic [QUEUE_CW-1:0]   cnt_r, cnt_nxt;
  logic                  pop;

  // Room for a full pair of results.
  assign room      = (cnt_r <= QUEUE_CW'(QUEUE_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign head      = mem[rd_r];
  assign pop       = out_valid && out_ready;
  assign cnt_nxt   = cnt_r + QUEUE_CW'(push.count) - QUEUE_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + QUEUE_AW'(push.count);
      rd_r  <= rd_r + QUEUE_AW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem[wr_r + QUEUE_AW'(1)] <= push.res1;
    end
  end

endmodule

[sv/block_stream_deframer_top.sv]
`timescale 1ns / 1ps
`include "block_stream_deframer_top_defines.svh"

// Block stream deframer. Signed 16-bit stream words arrive one per input
// transaction and are cut into blocks: a header of HEADER_WORDS words, whose
// words 6 and 7 hold the waveform count and the words per waveform, followed
// by their product in payload words. The first header word of each block
// yields a block-start result, and every payload word yields a payload result
// carrying its value, its 1-based stream position and a last-in-block flag.
// A negative count yields one error result and the block then ignores all
// input until reset. A word flagged end_of_stream that leaves a block
// incomplete yields a truncation result after any other result of that word,
// and the next word starts a new stream at position 1. The position counter
// is POSITION_BITS wide and wraps; the position port carries its low 32 bits.
// Timing: a word is registered at the input, processed by combinational logic
// (a counter step, plus one 15 by 15 multiply on header word 7) and its zero,
// one or two results are written into a four-entry result queue that drives
// the output ports. One word is accepted per cycle as long as results are
// taken at the same pace; each word passes the input register, then the
// queue. A word can yield two results while the output drains one per cycle,
// so the output port is the limit when truncations are frequent.
module block_stream_deframer_top #(
  parameter int HEADER_WORDS  = 8,
  parameter int POSITION_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [bsd_pkg::DATA_W-1:0] in_data_word,
  input  logic                              in_end_of_stream,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [bsd_pkg::POS_OUT_W-1:0]     out_position,
  output logic signed [bsd_pkg::DATA_W-1:0] out_payload_value,
  output logic                              out_last_in_block
);
  import bsd_pkg::*;

  push_t   push_s;
  result_t head_s;
  logic    room_s;

  // Header parsing, counters and result generation for one word per cycle while the queue has room.
  bsd_core #(
    .HEADER_WORDS  (HEADER_WORDS),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_word     (in_data_word),
    .in_end_of_stream (in_end_of_stream),
    .room             (room_s),
    .push             (push_s)
  );

  // Result queue; it decouples the output handshake from word processing.
  bsd_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_s),
    .room      (room_s),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head_s)
  );

  assign out_kind          = head_s.kind;
  assign out_position      = head_s.position;
  assign out_payload_value = head_s.payload_value;
  assign out_last_in_block = head_s.last_in_block;

  // Results are only written when the queue had room for a pair.
  `BSD_ASSERT(a_push_room, clk, rst_n, (push_s.count != 2'd0) |-> room_s)
  // A word never yields more than two results.
  `BSD_ASSERT(a_push_max, clk, rst_n, push_s.count != 2'd3)
  // Only payload results carry a value or the last-in-block flag.
  `BSD_ASSERT(a_non_payload_zero, clk, rst_n,
    (out_valid && out_kind != KIND_PAYLOAD) |-> (out_payload_value == '0 && !out_last_in_block))
  // The queue is empty in the cycle after reset.
  `BSD_ASSERT_ALL(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule
